// ===== hdl/uer_pkg.sv =====
// types, constants and register codes shared by the echo ranger files
// no dependencies
`timescale 1ns / 1ps

package uer_pkg;

  localparam int TICK_W      = 14;
  localparam int SINCE_W     = 16;
  localparam int DIST_W      = 8;
  localparam int DIV_STEPS   = TICK_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
  localparam int APB_ADDR_W  = 4;
  localparam int APB_DATA_W  = 32;

  localparam logic [7:0]         TPU_RESET      = 8'd29;
  localparam logic [SINCE_W-1:0] HOLDOFF_RESET  = 16'd1000;
  localparam logic [TICK_W-1:0]  TIMEOUT_RESET  = 14'd8000;
  localparam logic [7:0]         TRIG_RESET     = 8'd5;
  localparam logic [DIST_W-1:0]  DIST_TIMEOUT   = 8'd255;
  localparam logic [DIST_W-1:0]  DIST_RESET     = 8'd255;

  typedef enum logic [1:0] {
    CFG_TICKS_PER_UNIT = 2'd0,
    CFG_HOLDOFF        = 2'd1,
    CFG_ECHO_TIMEOUT   = 2'd2,
    CFG_TRIGGER        = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]         ticks_per_unit;
    logic [SINCE_W-1:0] holdoff_ticks;
    logic [TICK_W-1:0]  echo_timeout_ticks;
    logic [7:0]         trigger_ticks;
  } cfg_t;

  typedef struct packed {
    logic latch_in;
    logic eval;
    logic div_step;
    logic div_finish;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_need;
    logic div_last;
  } sts_t;

endpackage

// ===== hdl/uer_if.sv =====
// valid/ready channel interfaces for tick items and result items
// depends on nothing
`timescale 1ns / 1ps

interface uer_in_if;
  logic valid;
  logic ready;
  logic start_request;
  logic echo_level;

  modport source (output valid, start_request, echo_level, input ready);
  modport sink   (input valid, start_request, echo_level, output ready);
endinterface

interface uer_out_if;
  logic       valid;
  logic       ready;
  logic       trigger_level;
  logic       reading_valid;
  logic [7:0] distance;
  logic       timed_out;
  logic       from_cache;

  modport source (output valid, trigger_level, reading_valid, distance, timed_out,
                  from_cache, input ready);
  modport sink   (input valid, trigger_level, reading_valid, distance, timed_out,
                  from_cache, output ready);
endinterface

// ===== hdl/ultrasonic_echo_ranger_top.sv =====
// ultrasonic echo ranger: register file, controller and datapath
// depends on uer_pkg, uer_if, uer_ctrl, uer_dp
`timescale 1ns / 1ps

// Each item on in_ch is one timer tick carrying start_request and the sampled
// echo_level. Each tick yields exactly one result item on out_ch with the
// trigger pin level and, when reading_valid is set, a distance (255 with
// timed_out on an echo timeout, from_cache on a request inside hold-off).
// Items are processed one at a time: accept, one evaluate step, then the
// result goes to the output register. The tick that ends the echo high
// time runs the distance through a restoring divider, one quotient bit per
// cycle over all 14 quotient bits, plus a finishing step.
// The output register holds one finished result; while it waits, the next
// tick is already accepted and evaluated, and it waits in turn until the
// receiver takes the held result. A stalled receiver thus stalls in_ch.
// Reset (rst_ni low, asynchronous) returns to idle, empties the output
// register, loads the register reset values and sets the stored reading
// to 255. Registers are written over APB at byte address 4*index; the user
// must write only while no tick is in progress; the block does not enforce it.

module ultrasonic_echo_ranger_top import uer_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  uer_in_if.sink                in_ch,
  uer_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t     cfg_q;
  cmd_t     cmd;
  sts_t     sts;
  cfg_idx_e idx;
  logic     wr_en;

  assign idx    = cfg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_unit     <= TPU_RESET;
      cfg_q.holdoff_ticks      <= HOLDOFF_RESET;
      cfg_q.echo_timeout_ticks <= TIMEOUT_RESET;
      cfg_q.trigger_ticks      <= TRIG_RESET;
    end else if (wr_en) begin
      case (idx)
        CFG_TICKS_PER_UNIT: cfg_q.ticks_per_unit     <= pwdata[7:0];
        CFG_HOLDOFF:        cfg_q.holdoff_ticks      <= pwdata[SINCE_W-1:0];
        CFG_ECHO_TIMEOUT:   cfg_q.echo_timeout_ticks <= pwdata[TICK_W-1:0];
        CFG_TRIGGER:        cfg_q.trigger_ticks      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      CFG_TICKS_PER_UNIT: prdata = {{(APB_DATA_W-8){1'b0}}, cfg_q.ticks_per_unit};
      CFG_HOLDOFF:        prdata = {{(APB_DATA_W-SINCE_W){1'b0}}, cfg_q.holdoff_ticks};
      CFG_ECHO_TIMEOUT:   prdata = {{(APB_DATA_W-TICK_W){1'b0}}, cfg_q.echo_timeout_ticks};
      CFG_TRIGGER:        prdata = {{(APB_DATA_W-8){1'b0}}, cfg_q.trigger_ticks};
      default:            prdata = '0;
    endcase
  end

  uer_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  uer_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .start_request_i (in_ch.start_request),
    .echo_level_i    (in_ch.echo_level),
    .trigger_level_o (out_ch.trigger_level),
    .reading_valid_o (out_ch.reading_valid),
    .distance_o      (out_ch.distance),
    .timed_out_o     (out_ch.timed_out),
    .from_cache_o    (out_ch.from_cache)
  );

endmodule

// ===== hdl/uer_ctrl.sv =====
// sequencing fsm: accept, evaluate, serial divide, push to output register
// depends on uer_pkg
`timescale 1ns / 1ps

module uer_ctrl import uer_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_FIN,
    S_PUSH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o            = '0;
    state_d          = state_q;
    cmd_o.latch_in   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.load_out   = (state_q == S_PUSH) && (!out_valid_q || out_ready_i);
    out_valid_d      = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.div_need ? S_DIV : S_PUSH;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.div_finish = 1'b1;
        state_d          = S_PUSH;
      end
      S_PUSH: begin
        if (cmd_o.load_out) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/uer_dp.sv =====
// datapath: ranging state, step evaluation, restoring divider, output payload
// depends on uer_pkg
`timescale 1ns / 1ps

module uer_dp import uer_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic              start_request_i,
  input  logic              echo_level_i,
  output logic              trigger_level_o,
  output logic              reading_valid_o,
  output logic [DIST_W-1:0] distance_o,
  output logic              timed_out_o,
  output logic              from_cache_o
);

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_TRIG_HIGH = 3'd1,
    PH_WAIT_LOW  = 3'd2,
    PH_WAIT_HIGH = 3'd3,
    PH_MEASURE   = 3'd4
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [TICK_W-1:0]   ticks_q, ticks_d;
  logic [SINCE_W-1:0]  since_q, since_d;
  logic [DIST_W-1:0]   last_q;
  logic                req_q, echo_q;

  logic                res_trig_q, res_trig_d;
  logic                res_valid_q, res_valid_d;
  logic [DIST_W-1:0]   res_dist_q, res_dist_d;
  logic                res_tmo_q, res_tmo_d;
  logic                res_cache_q, res_cache_d;

  logic [TICK_W-1:0]   acc_q, acc_d;
  logic [7:0]          rem_q, rem_d;
  logic [7:0]          dv_q;
  logic [DIV_CNT_W-1:0] cnt_q;

  logic [TICK_W:0]     n;
  logic [7:0]          trig_len;
  logic [7:0]          divisor;
  logic [SINCE_W-1:0]  elapsed;
  logic                seen;
  logic                div_need;
  logic [8:0]          trial;
  logic                qbit;
  logic [DIST_W-1:0]   quo_sat;

  assign n        = {1'b0, ticks_q} + {{TICK_W{1'b0}}, 1'b1};
  assign trig_len = (cfg_i.trigger_ticks == 8'd0) ? 8'd1 : cfg_i.trigger_ticks;
  assign divisor  = (cfg_i.ticks_per_unit == 8'd0) ? 8'd1 : cfg_i.ticks_per_unit;

  // one tick of the ranging sequence
  always_comb begin
    phase_d     = phase_q;
    ticks_d     = ticks_q;
    elapsed     = since_q;
    div_need    = 1'b0;
    seen        = (phase_q == PH_WAIT_HIGH) ? echo_q : !echo_q;
    res_trig_d  = 1'b0;
    res_valid_d = 1'b0;
    res_dist_d  = '0;
    res_tmo_d   = 1'b0;
    res_cache_d = 1'b0;
    case (phase_q)
      PH_TRIG_HIGH: begin
        res_trig_d = 1'b1;
        if (n >= {{(TICK_W-7){1'b0}}, trig_len}) begin
          phase_d = PH_WAIT_LOW;
          ticks_d = '0;
        end else begin
          ticks_d = n[TICK_W-1:0];
        end
      end
      PH_WAIT_LOW, PH_WAIT_HIGH, PH_MEASURE: begin
        if (seen) begin
          ticks_d = '0;
          case (phase_q)
            PH_WAIT_LOW:  phase_d = PH_WAIT_HIGH;
            PH_WAIT_HIGH: phase_d = PH_MEASURE;
            default: begin
              // distance filled in once the divider is done
              phase_d     = PH_IDLE;
              res_valid_d = 1'b1;
              div_need    = 1'b1;
            end
          endcase
        end else if (n >= {1'b0, cfg_i.echo_timeout_ticks}) begin
          phase_d     = PH_IDLE;
          ticks_d     = '0;
          res_valid_d = 1'b1;
          res_dist_d  = DIST_TIMEOUT;
          res_tmo_d   = 1'b1;
        end else begin
          ticks_d = n[TICK_W-1:0];
        end
      end
      default: begin
        phase_d = PH_IDLE;
        ticks_d = '0;
        if (req_q) begin
          if (since_q < cfg_i.holdoff_ticks) begin
            res_valid_d = 1'b1;
            res_dist_d  = last_q;
            res_cache_d = 1'b1;
          end else begin
            // trigger low tick
            elapsed = '0;
            phase_d = PH_TRIG_HIGH;
          end
        end
      end
    endcase
    since_d = (elapsed == {SINCE_W{1'b1}}) ? elapsed : elapsed + {{(SINCE_W-1){1'b0}}, 1'b1};
  end

  // restoring divide, one quotient bit per cycle
  assign trial   = {rem_q, acc_q[TICK_W-1]};
  assign qbit    = (trial >= {1'b0, dv_q});
  assign rem_d   = qbit ? 8'(trial - {1'b0, dv_q}) : trial[7:0];
  assign acc_d   = {acc_q[TICK_W-2:0], qbit};
  assign quo_sat = (acc_q[TICK_W-1:DIST_W] != '0) ? DIST_TIMEOUT : acc_q[DIST_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      ticks_q <= '0;
      since_q <= '0;
      last_q  <= DIST_RESET;
      cnt_q   <= '0;
    end else begin
      if (cmd_i.eval) begin
        phase_q <= phase_d;
        ticks_q <= ticks_d;
        since_q <= since_d;
        if (div_need) cnt_q <= DIV_CNT_W'(DIV_STEPS);
      end
      if (cmd_i.div_step) cnt_q <= cnt_q - {{(DIV_CNT_W-1){1'b0}}, 1'b1};
      if (cmd_i.div_finish) last_q <= quo_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      req_q  <= start_request_i;
      echo_q <= echo_level_i;
    end
    if (cmd_i.eval) begin
      res_trig_q  <= res_trig_d;
      res_valid_q <= res_valid_d;
      res_dist_q  <= res_dist_d;
      res_tmo_q   <= res_tmo_d;
      res_cache_q <= res_cache_d;
      if (div_need) begin
        acc_q <= n[TICK_W-1:0];
        rem_q <= '0;
        dv_q  <= divisor;
      end
    end
    if (cmd_i.div_step) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
    if (cmd_i.div_finish) res_dist_q <= quo_sat;
    if (cmd_i.load_out) begin
      trigger_level_o <= res_trig_q;
      reading_valid_o <= res_valid_q;
      distance_o      <= res_dist_q;
      timed_out_o     <= res_tmo_q;
      from_cache_o    <= res_cache_q;
    end
  end

  assign sts_o.div_need = div_need;
  assign sts_o.div_last = (cnt_q == {{(DIV_CNT_W-1){1'b0}}, 1'b1});

endmodule

// ===== tb/tb_ultrasonic_echo_ranger_top.sv =====
// self-checking testbench for the ultrasonic echo ranger top level
// depends on uer_pkg, uer_if and ultrasonic_echo_ranger_top
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranger_top;
  import uer_pkg::*;

  localparam int HALF_PERIOD     = 5;
  localparam int RESET_CYCLES    = 9;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int SETTLE_CYCLES   = 4;
  localparam int N_PHASES        = 9;
  localparam int FIRST_PHASE_LEN = 300;
  localparam int PHASE_LEN       = 65;

  typedef struct packed {
    logic             trigger_level;
    logic             reading_valid;
    logic [DIST_W-1:0] distance;
    logic             timed_out;
    logic             from_cache;
  } tick_result_t;

  typedef enum logic [2:0] {
    RS_IDLE,
    RS_TRIG_HIGH,
    RS_WAIT_LOW,
    RS_WAIT_HIGH,
    RS_MEASURE
  } ranger_state_e;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e    kind;
    cfg_idx_e     idx;
    logic [31:0]  data;
    bit           req;
    bit           echo;
    bit           typed;
    tick_result_t res;
  } stim_row_t;

  localparam tick_result_t RES_QUIET       = '{1'b0, 1'b0, 8'd0, 1'b0, 1'b0};
  localparam tick_result_t RES_TRIG        = '{1'b1, 1'b0, 8'd0, 1'b0, 1'b0};
  localparam tick_result_t RES_TIMEOUT     = '{1'b0, 1'b1, DIST_TIMEOUT, 1'b1, 1'b0};
  localparam tick_result_t RES_RESET_CACHE = '{1'b0, 1'b1, DIST_RESET, 1'b0, 1'b1};

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  uer_in_if  in_ch ();
  uer_out_if out_ch ();

  ultrasonic_echo_ranger_top DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #(HALF_PERIOD) clk_i = 1'b1;
    #(HALF_PERIOD) clk_i = 1'b0;
  end

  // predictor copy of the register file
  logic [7:0]         cfg_tpu     = TPU_RESET;
  logic [SINCE_W-1:0] cfg_holdoff = HOLDOFF_RESET;
  logic [TICK_W-1:0]  cfg_timeout = TIMEOUT_RESET;
  logic [7:0]         cfg_trig    = TRIG_RESET;

  // predictor copy of the ranging state
  ranger_state_e     rs_state     = RS_IDLE;
  int                rs_ticks     = 0;
  int                rs_since     = 0;
  logic [DIST_W-1:0] rs_last_dist = DIST_RESET;

  tick_result_t tick_results_q[$];
  stim_row_t    directed_rows[$];

  int send_idle = 0;
  int recv_idle = 0;
  int pulse_left = 0;
  int long_pct = 10;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int n_ticks = 0;
  int n_measured = 0;
  int n_saturated = 0;
  int n_timeouts = 0;
  int n_cached = 0;
  tick_result_t got_res;
  tick_result_t want_res;

  function automatic tick_result_t ranger_predict(bit req, bit echo);
    tick_result_t r;
    int elapsed;
    int n;
    int trig_len;
    int divisor;
    int quot;
    bit seen;
    r = RES_QUIET;
    elapsed = rs_since;
    n = rs_ticks + 1;
    trig_len = (cfg_trig == 0) ? 1 : int'(cfg_trig);
    divisor = (cfg_tpu == 0) ? 1 : int'(cfg_tpu);
    case (rs_state)
      RS_TRIG_HIGH: begin
        r.trigger_level = 1'b1;
        if (n >= trig_len) begin
          rs_state = RS_WAIT_LOW;
          rs_ticks = 0;
        end else begin
          rs_ticks = n;
        end
      end
      RS_WAIT_LOW, RS_WAIT_HIGH, RS_MEASURE: begin
        seen = (rs_state == RS_WAIT_HIGH) ? echo : !echo;
        if (seen) begin
          if (rs_state == RS_MEASURE) begin
            quot = n / divisor;
            if (quot > 255) begin
              quot = 255;
              n_saturated++;
            end
            rs_last_dist = quot[DIST_W-1:0];
            r.reading_valid = 1'b1;
            r.distance = quot[DIST_W-1:0];
            rs_state = RS_IDLE;
            n_measured++;
          end else begin
            rs_state = (rs_state == RS_WAIT_LOW) ? RS_WAIT_HIGH : RS_MEASURE;
          end
          rs_ticks = 0;
        end else if (n >= int'(cfg_timeout)) begin
          r = RES_TIMEOUT;
          rs_state = RS_IDLE;
          rs_ticks = 0;
          n_timeouts++;
        end else begin
          rs_ticks = n;
        end
      end
      default: begin
        rs_state = RS_IDLE;
        rs_ticks = 0;
        if (req) begin
          if (elapsed < int'(cfg_holdoff)) begin
            r.reading_valid = 1'b1;
            r.distance = rs_last_dist;
            r.from_cache = 1'b1;
            n_cached++;
          end else begin
            // this tick is the trigger low tick
            elapsed = 0;
            rs_state = RS_TRIG_HIGH;
          end
        end
      end
    endcase
    rs_since = (elapsed >= 65535) ? 65535 : elapsed + 1;
    return r;
  endfunction

  function automatic void add_tick(bit req, bit echo);
    stim_row_t row;
    row = '{ROW_TICK, CFG_TICKS_PER_UNIT, 32'd0, req, echo, 1'b0, RES_QUIET};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_check(bit req, bit echo, tick_result_t res);
    stim_row_t row;
    row = '{ROW_TICK, CFG_TICKS_PER_UNIT, 32'd0, req, echo, 1'b1, res};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(cfg_idx_e idx, logic [31:0] data);
    stim_row_t row;
    row = '{ROW_CFG, idx, data, 1'b0, 1'b0, 1'b0, RES_QUIET};
    directed_rows.push_back(row);
  endfunction

  // one tick item; the expectation is the typed one when given, else the predicted one
  task automatic send_tick(bit req, bit echo, bit typed, tick_result_t res);
    tick_result_t predicted;
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid         <= 1'b1;
    in_ch.start_request <= req;
    in_ch.echo_level    <= echo;
    do @(posedge clk_i); while (!in_ch.ready);
    predicted = ranger_predict(req, echo);
    tick_results_q.push_back(typed ? res : predicted);
    n_ticks++;
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_quiet();
    while (tick_results_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    release_input();
    wait_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      CFG_TICKS_PER_UNIT: cfg_tpu     = data[7:0];
      CFG_HOLDOFF:        cfg_holdoff = data[SINCE_W-1:0];
      CFG_ECHO_TIMEOUT:   cfg_timeout = data[TICK_W-1:0];
      default:            cfg_trig    = data[7:0];
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // echo follows a plausible sensor: low before the pulse, then a high pulse of
  // planned width, with some noise mixed in
  task automatic next_tick(output bit req, output bit echo);
    req = ($urandom_range(99) < 40);
    case (rs_state)
      RS_WAIT_LOW:  echo = ($urandom_range(99) < 25);
      RS_WAIT_HIGH: begin
        echo = ($urandom_range(99) < 35);
        if (echo) begin
          pulse_left = ($urandom_range(99) < long_pct) ? $urandom_range(250, 300)
                                                        : $urandom_range(0, 40);
        end
      end
      RS_MEASURE: begin
        echo = (pulse_left != 0);
        if (pulse_left != 0) pulse_left--;
      end
      default: echo = 1'($urandom_range(1));
    endcase
    if ($urandom_range(99) < 8) echo = 1'($urandom_range(1));
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got_res = '{out_ch.trigger_level, out_ch.reading_valid, out_ch.distance,
                  out_ch.timed_out, out_ch.from_cache};
      if (tick_results_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result item trig=%0b valid=%0b dist=%0d tmo=%0b cache=%0b",
                 $time, got_res.trigger_level, got_res.reading_valid, got_res.distance,
                 got_res.timed_out, got_res.from_cache);
      end else begin
        want_res = tick_results_q.pop_front();
        if (got_res !== want_res) begin
          err_cnt++;
          $write("%0t: mismatch expected trig=%0b valid=%0b dist=%0d tmo=%0b cache=%0b,",
                 $time, want_res.trigger_level, want_res.reading_valid,
                 want_res.distance, want_res.timed_out, want_res.from_cache);
          $display(" actual trig=%0b valid=%0b dist=%0d tmo=%0b cache=%0b",
                   got_res.trigger_level, got_res.reading_valid, got_res.distance,
                   got_res.timed_out, got_res.from_cache);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles with %0d results outstanding",
               $time, CYCLE_LIMIT, tick_results_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    bit          req;
    bit          echo;
    int          items;
    logic [31:0] wdata;
    rst_ni              = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.start_request = 1'b0;
    in_ch.echo_level    = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;

    // right after reset: hold-off still open, stored reading is the reset value
    add_check(1'b0, 1'b0, RES_QUIET);
    add_check(1'b1, 1'b1, RES_RESET_CACHE);
    // zero hold-off; zero divisor and zero trigger length via dropped upper bits
    add_cfg(CFG_HOLDOFF, 32'h0000_0000);
    add_cfg(CFG_TICKS_PER_UNIT, 32'h5A5A_5A00);
    add_cfg(CFG_TRIGGER, 32'hFFFF_FF00);
    add_cfg(CFG_ECHO_TIMEOUT, 32'h0000_0003);
    add_check(1'b1, 1'b1, RES_QUIET);
    add_check(1'b1, 1'b0, RES_TRIG);    // request while busy is ignored
    add_tick(1'b0, 1'b1);
    add_tick(1'b0, 1'b0);
    add_tick(1'b0, 1'b1);
    add_tick(1'b1, 1'b1);
    add_tick(1'b0, 1'b1);
    add_tick(1'b0, 1'b0);                // end of echo pulse, reading of 3
    // echo stuck high during the low wait runs into the timeout
    add_check(1'b1, 1'b1, RES_QUIET);
    add_check(1'b0, 1'b1, RES_TRIG);
    add_tick(1'b0, 1'b1);
    add_tick(1'b0, 1'b1);
    add_check(1'b0, 1'b1, RES_TIMEOUT);
    // zero timeout: a wait that misses its level on the first tick times out
    add_cfg(CFG_ECHO_TIMEOUT, 32'hFFFF_C000);
    add_check(1'b1, 1'b0, RES_QUIET);
    add_check(1'b0, 1'b0, RES_TRIG);
    add_tick(1'b0, 1'b0);
    add_check(1'b0, 1'b0, RES_TIMEOUT);
    // widest settings; the timeouts left the stored reading alone
    add_cfg(CFG_HOLDOFF, 32'h0000_FFFF);
    add_cfg(CFG_TICKS_PER_UNIT, 32'h0000_00FF);
    add_cfg(CFG_ECHO_TIMEOUT, 32'h0000_3FFF);
    add_cfg(CFG_TRIGGER, 32'h0000_00FF);
    add_tick(1'b1, 1'b0);
    add_check(1'b0, 1'b1, RES_QUIET);

    send_idle = 9;
    recv_idle = 55;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_tick(directed_rows[i].req, directed_rows[i].echo, directed_rows[i].typed,
                  directed_rows[i].res);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph == 3) begin
        send_idle = 55;
        recv_idle = 9;
      end else if (ph == 6) begin
        send_idle = 0;
        recv_idle = 0;
      end
      long_pct = (ph == 0) ? 60 : 10;
      items = (ph == 0) ? FIRST_PHASE_LEN : PHASE_LEN;
      // upper bits of every write are random and must be dropped
      wdata = $urandom;
      case (ph)
        0: wdata[7:0] = 8'd1;
        1: wdata[7:0] = 8'd255;
        2: wdata[7:0] = 8'd0;
        default: wdata[7:0] = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                      : 8'($urandom_range(1, 6));
      endcase
      write_reg(CFG_TICKS_PER_UNIT, wdata);
      wdata = $urandom;
      case (ph)
        0, 1: wdata[15:0] = 16'd0;
        2: wdata[15:0] = 16'd3;
        default: wdata[15:0] = 16'($urandom_range(0, 40));
      endcase
      write_reg(CFG_HOLDOFF, wdata);
      wdata = $urandom;
      case (ph)
        0: wdata[TICK_W-1:0] = 14'd16383;
        1: wdata[TICK_W-1:0] = 14'd1;
        2: wdata[TICK_W-1:0] = 14'd0;
        default: wdata[TICK_W-1:0] = ($urandom_range(9) == 0)
                                     ? 14'($urandom_range(300, 16383))
                                     : 14'($urandom_range(0, 60));
      endcase
      write_reg(CFG_ECHO_TIMEOUT, wdata);
      wdata = $urandom;
      case (ph)
        0: wdata[7:0] = 8'd1;
        1: wdata[7:0] = 8'd255;
        2: wdata[7:0] = 8'd0;
        default: wdata[7:0] = 8'($urandom_range(0, 6));
      endcase
      write_reg(CFG_TRIGGER, wdata);

      for (int k = 0; k < items; k++) begin
        next_tick(req, echo);
        send_tick(req, echo, 1'b0, RES_QUIET);
      end
    end

    release_input();
    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d ticks over %0d register settings plus the directed part",
             n_ticks, N_PHASES);
    $display("readings: %0d measured (%0d saturated), %0d timeouts, %0d from hold-off store",
             n_measured, n_saturated, n_timeouts, n_cached);
    if (err_cnt == 0 && tick_results_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d errors, %0d results still expected", err_cnt, tick_results_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/uer_pkg.sv
hdl/uer_if.sv
hdl/uer_ctrl.sv
hdl/uer_dp.sv
hdl/ultrasonic_echo_ranger_top.sv
tb/tb_ultrasonic_echo_ranger_top.sv
